// ===== rtl/core/tbc_pkg.sv =====
// Shared types and constants for the thermistor beta-equation temperature core.
package tbc_pkg;

  localparam int ADC_W      = 16;
  localparam int SERIES_W   = 20;
  localparam int BETA_W     = 14;
  localparam int T0_W       = 15;
  localparam int TEMP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int PROD_W   = 36;            // series*(full-code) and code*R0
  localparam int LOG_FRAC = 30;            // log2 fraction bits
  localparam int LOG_K_W  = 6;             // log2 integer part
  localparam int DIFF_W   = LOG_K_W + LOG_FRAC + 1;
  localparam int LN_W     = 36;
  localparam int RDIV_N_W = 51;            // dividend of the two reciprocal dividers
  localparam int RDIV_D_W = 16;
  localparam int Y_W      = 53;
  localparam int TK_N_W   = 52;
  localparam int TK_D_W   = 51;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [RDIV_N_W-1:0] RECIP_NUM = 51'd100 << 44;   // 1.0 K^-1 in Q44 scaled by 100
  localparam logic [15:0] KELVIN_CENTI = 16'd27315;
  localparam logic [TK_N_W-1:0] TK_MAX = 52'd60082;            // 32767 + 27315
  localparam logic signed [TEMP_W-1:0] OUT_MAX = 16'sd32767;
  localparam logic signed [TEMP_W-1:0] OUT_MIN = -16'sd27315;

  localparam logic [SERIES_W-1:0] RES_MAX  = 20'd1000000;
  localparam logic [BETA_W-1:0]   BETA_MAX = 14'd10000;
  localparam logic signed [T0_W-1:0] T0_LO = -15'sd4000;
  localparam logic signed [T0_W-1:0] T0_HI = 15'sd15000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_FULL = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES  = 2'd0,
    REG_NOMINAL = 2'd1,
    REG_BETA    = 2'd2,
    REG_T0      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic code_zero;
    logic code_full;
  } code_flags_t;

endpackage

// ===== rtl/core/tbc_ifs.sv =====
// Valid/ready stream interfaces for ADC samples and temperature results.
interface tbc_in_if import tbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_code;

  modport source(output valid, output adc_code, input ready);
  modport sink(input valid, input adc_code, output ready);
endinterface

interface tbc_out_if import tbc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [1:0]               status;

  modport source(output valid, output temperature_centi, output status, input ready);
  modport sink(input valid, input temperature_centi, input status, output ready);
endinterface

// ===== rtl/core/thermistor_beta_to_celsius_core.sv =====
// NTC thermistor beta-equation converter: one ADC code per beat in, one temperature per beat
// out. Fully pipelined: a new sample is taken every cycle while the skid entry is free, and the
// pipeline depth is set mostly by the 30 squaring rounds of the log2 unit and
// the two bit-per-stage dividers (51 and 52 stages). A two-entry output buffer lets the pipeline
// keep taking samples while one result waits; ready drops only when both entries are full.
// Registers are clamped to their legal ranges when written and should only change while idle.
module thermistor_beta_to_celsius_core import tbc_pkg::*; #(
  parameter int ADC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tbc_in_if.sink                in_ch,
  tbc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [ADC_W-1:0] FULL_CODE = ADC_W'((32'd1 << ADC_BITS) - 32'd1);

  // configuration
  logic [SERIES_W-1:0]    series_r;
  logic [SERIES_W-1:0]    nominal_r;
  logic [BETA_W-1:0]      beta_r;
  logic signed [T0_W-1:0] t0_r;

  logic [SERIES_W-1:0]    res_clamp;
  logic [BETA_W-1:0]      beta_clamp;
  logic signed [T0_W-1:0] t0_raw;
  logic signed [T0_W-1:0] t0_clamp;

  always_comb begin
    if (cfg_data == '0) res_clamp = SERIES_W'(1);
    else if (cfg_data > RES_MAX) res_clamp = RES_MAX;
    else res_clamp = cfg_data;

    if (cfg_data[BETA_W-1:0] == '0) beta_clamp = BETA_W'(1);
    else if (cfg_data[BETA_W-1:0] > BETA_MAX) beta_clamp = BETA_MAX;
    else beta_clamp = cfg_data[BETA_W-1:0];

    t0_raw = $signed(cfg_data[T0_W-1:0]);
    if (t0_raw < T0_LO) t0_clamp = T0_LO;
    else if (t0_raw > T0_HI) t0_clamp = T0_HI;
    else t0_clamp = t0_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r  <= 20'd10000;
      nominal_r <= 20'd10000;
      beta_r    <= 14'd3900;
      t0_r      <= 15'sd2500;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_SERIES:  series_r  <= res_clamp;
        REG_NOMINAL: nominal_r <= res_clamp;
        REG_BETA:    beta_r    <= beta_clamp;
        REG_T0:      t0_r      <= t0_clamp;
        default: ;
      endcase
    end
  end

  logic signed [T0_W+1:0] t0_kel_s;
  logic [RDIV_D_W-1:0]    t0_kel;
  assign t0_kel_s = {{2{t0_r[T0_W-1]}}, t0_r} + $signed({1'b0, KELVIN_CENTI});
  assign t0_kel   = t0_kel_s[RDIV_D_W-1:0];

  // pipeline advances while the skid entry is free
  logic skid_v_r;
  logic en;
  assign en = !skid_v_r;
  assign in_ch.ready = en;

  // stage 1: divider resistances
  logic [ADC_W-1:0]  code_gap;
  logic [PROD_W-1:0] num_nxt, den_nxt;
  code_flags_t       flags_nxt;

  assign code_gap  = FULL_CODE - in_ch.adc_code;
  assign num_nxt   = PROD_W'(series_r) * PROD_W'(code_gap);
  assign den_nxt   = PROD_W'(in_ch.adc_code) * PROD_W'(nominal_r);
  assign flags_nxt = '{code_zero: in_ch.adc_code == '0,
                       code_full: in_ch.adc_code >= FULL_CODE};

  logic              v1_r;
  logic [PROD_W-1:0] num1_r, den1_r;
  code_flags_t       flags1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid && in_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r   <= num_nxt;
      den1_r   <= den_nxt;
      flags1_r <= flags_nxt;
    end
  end

  // log ratio
  logic                     lr_v;
  logic signed [DIFF_W-1:0] lr_diff;
  code_flags_t              lr_flags;

  tbc_logratio #(.SW($bits(code_flags_t))) u_logratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_num    (num1_r),
    .in_den    (den1_r),
    .in_side   (flags1_r),
    .out_valid (lr_v),
    .out_diff  (lr_diff),
    .out_side  (lr_flags)
  );

  // natural log magnitude: |d| * ln2
  logic [DIFF_W-1:0] lr_mag;
  logic [63:0]       ln_prod;
  assign lr_mag  = lr_diff[DIFF_W-1] ? DIFF_W'(-lr_diff) : DIFF_W'(lr_diff);
  assign ln_prod = 64'(lr_mag[LN_W-1:2]) * 64'(LN2_Q30);

  logic            v3_r;
  logic [LN_W-1:0] ln3_r;
  logic            sign3_r;
  code_flags_t     flags3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= lr_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln3_r    <= ln_prod[63:28];
      sign3_r  <= lr_diff[DIFF_W-1];
      flags3_r <= lr_flags;
    end
  end

  // ln(R/R0)/beta and 1/T0, side by side
  logic                da_v;
  logic [RDIV_N_W-1:0] qa, qb;
  code_flags_t         da_flags;
  logic                db_v;
  logic                db_sign;

  tbc_div #(.NW(RDIV_N_W), .DW(RDIV_D_W), .SW($bits(code_flags_t))) u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    ({1'b0, ln3_r, 14'b0}),
    .in_den    ({2'b0, beta_r}),
    .in_side   (flags3_r),
    .out_valid (da_v),
    .out_quot  (qa),
    .out_side  (da_flags)
  );

  tbc_div #(.NW(RDIV_N_W), .DW(RDIV_D_W), .SW(1)) u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_num    (RECIP_NUM),
    .in_den    (t0_kel),
    .in_side   (sign3_r),
    .out_valid (db_v),
    .out_quot  (qb),
    .out_side  (db_sign)
  );

  // sum of reciprocals
  logic signed [Y_W-1:0] a_s, y_nxt;
  status_t               pre_nxt;
  assign a_s   = db_sign ? -$signed({2'b0, qa}) : $signed({2'b0, qa});
  assign y_nxt = a_s + $signed({2'b0, qb});

  always_comb begin
    if (da_flags.code_zero) pre_nxt = ST_ZERO;
    else if (da_flags.code_full) pre_nxt = ST_FULL;
    else if (y_nxt[Y_W-1] || y_nxt == '0) pre_nxt = ST_SAT;
    else pre_nxt = ST_OK;
  end

  logic                  v4_r;
  logic signed [Y_W-1:0] y4_r;
  status_t               st4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= da_v && db_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y4_r  <= y_nxt;
      st4_r <= pre_nxt;
    end
  end

  // rounded reciprocal operands
  logic              v5_r;
  logic [TK_N_W-1:0] tkn5_r;
  logic [TK_D_W-1:0] tkd5_r;
  status_t           st5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tkn5_r <= TK_N_W'(RECIP_NUM) + TK_N_W'(y4_r[Y_W-1:1]);
      tkd5_r <= y4_r[TK_D_W-1:0];
      st5_r  <= st4_r;
    end
  end

  logic              dt_v;
  logic [TK_N_W-1:0] tk;
  logic [1:0]        dt_st_bits;
  status_t           dt_st;

  tbc_div #(.NW(TK_N_W), .DW(TK_D_W), .SW($bits(status_t))) u_div_tk (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_num    (tkn5_r),
    .in_den    (tkd5_r),
    .in_side   (st5_r),
    .out_valid (dt_v),
    .out_quot  (tk),
    .out_side  (dt_st_bits)
  );

  assign dt_st = status_t'(dt_st_bits);

  // final selection
  logic signed [TEMP_W-1:0] temp_nxt;
  status_t                  st_nxt;

  always_comb begin
    st_nxt   = dt_st;
    temp_nxt = OUT_MAX;
    case (dt_st)
      ST_ZERO: temp_nxt = OUT_MIN;
      ST_OK: begin
        if (tk > TK_MAX) st_nxt = ST_SAT;
        else temp_nxt = $signed(tk[TEMP_W-1:0] - KELVIN_CENTI);
      end
      default: temp_nxt = OUT_MAX;
    endcase
  end

  // output register plus skid entry
  logic                     out_v_r;
  logic signed [TEMP_W-1:0] out_temp_r, skid_temp_r;
  status_t                  out_st_r, skid_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) skid_v_r <= 1'b0;
    end else if (dt_v) begin
      if (!out_v_r || out_ch.ready) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ch.ready) begin
        out_temp_r <= skid_temp_r;
        out_st_r   <= skid_st_r;
      end
    end else if (dt_v) begin
      if (!out_v_r || out_ch.ready) begin
        out_temp_r <= temp_nxt;
        out_st_r   <= st_nxt;
      end else begin
        skid_temp_r <= temp_nxt;
        skid_st_r   <= st_nxt;
      end
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.status            = out_st_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a beat while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && out_v_r)
    else $error("skid beat lost during output stall");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_st_r == ST_ZERO |-> out_temp_r == OUT_MIN)
    else $error("zero code without minimum temperature");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_st_r == ST_FULL || out_st_r == ST_SAT) |-> out_temp_r == OUT_MAX)
    else $error("saturated beat without maximum temperature");
`endif

endmodule

// ===== rtl/core/tbc_logratio.sv =====
// Pipelined log2(num) - log2(den) in Q30, one squaring round per stage.
module tbc_logratio import tbc_pkg::*; #(
  parameter int SW = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [PROD_W-1:0]        in_num,
  input  logic [PROD_W-1:0]        in_den,
  input  logic [SW-1:0]            in_side,
  output logic                     out_valid,
  output logic signed [DIFF_W-1:0] out_diff,
  output logic [SW-1:0]            out_side
);

  typedef struct packed {
    logic [LOG_K_W-1:0]  k;
    logic [LOG_FRAC:0]   m;
  } lognorm_t;

  function automatic lognorm_t normalize(input logic [PROD_W-1:0] x);
    lognorm_t          res;
    logic [PROD_W-1:0] sh;
    res.k = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (x[i]) res.k = LOG_K_W'(i);
    end
    if (res.k > LOG_K_W'(LOG_FRAC)) sh = x >> (res.k - LOG_K_W'(LOG_FRAC));
    else sh = x << (LOG_K_W'(LOG_FRAC) - res.k);
    res.m = sh[LOG_FRAC:0];
    return res;
  endfunction

  logic                vld_r  [LOG_FRAC+1];
  logic [SW-1:0]       side_r [LOG_FRAC+1];
  logic [LOG_K_W-1:0]  kn_r   [LOG_FRAC+1];
  logic [LOG_K_W-1:0]  kd_r   [LOG_FRAC+1];
  logic [LOG_FRAC:0]   mn_r   [LOG_FRAC+1];
  logic [LOG_FRAC:0]   md_r   [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] fn_r   [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] fd_r   [LOG_FRAC+1];

  lognorm_t norm_n, norm_d;
  assign norm_n = normalize(in_num);
  assign norm_d = normalize(in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      kn_r[0]   <= norm_n.k;
      kd_r[0]   <= norm_d.k;
      mn_r[0]   <= norm_n.m;
      md_r[0]   <= norm_d.m;
      fn_r[0]   <= '0;
      fd_r[0]   <= '0;
    end
  end

  // each round squares the mantissa; overflow past 2.0 yields the next fraction bit
  for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_round
    logic [2*LOG_FRAC+1:0] sqn, sqd;
    logic [LOG_FRAC+1:0]   hin, hid;

    assign sqn = mn_r[i-1] * mn_r[i-1];
    assign sqd = md_r[i-1] * md_r[i-1];
    assign hin = sqn[2*LOG_FRAC+1:LOG_FRAC];
    assign hid = sqd[2*LOG_FRAC+1:LOG_FRAC];

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (en) vld_r[i] <= vld_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_r[i-1];
        kn_r[i]   <= kn_r[i-1];
        kd_r[i]   <= kd_r[i-1];
        mn_r[i]   <= hin[LOG_FRAC+1] ? hin[LOG_FRAC+1:1] : hin[LOG_FRAC:0];
        md_r[i]   <= hid[LOG_FRAC+1] ? hid[LOG_FRAC+1:1] : hid[LOG_FRAC:0];
        fn_r[i]   <= {fn_r[i-1][LOG_FRAC-2:0], hin[LOG_FRAC+1]};
        fd_r[i]   <= {fd_r[i-1][LOG_FRAC-2:0], hid[LOG_FRAC+1]};
      end
    end
  end

  logic                     out_valid_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [SW-1:0]            out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_r[LOG_FRAC];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r     <= $signed({1'b0, kn_r[LOG_FRAC], fn_r[LOG_FRAC]})
                  - $signed({1'b0, kd_r[LOG_FRAC], fd_r[LOG_FRAC]});
      out_side_r <= side_r[LOG_FRAC];
    end
  end

  assign out_valid = out_valid_r;
  assign out_diff  = diff_r;
  assign out_side  = out_side_r;

endmodule

// ===== rtl/core/tbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tbc_div #(
  parameter int NW = 51,
  parameter int DW = 16,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quot_r [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_head
      assign v_in = in_valid;
      assign r_in = '0;
      assign d_in = in_den;
      assign n_in = in_num;
      assign q_in = '0;
      assign s_in = in_side;
    end else begin : g_body
      assign v_in = vld_r[i-1];
      assign r_in = rem_r[i-1];
      assign d_in = den_r[i-1];
      assign n_in = num_r[i-1];
      assign q_in = quot_r[i-1];
      assign s_in = side_r[i-1];
    end

    assign trial = {r_in, n_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (en) vld_r[i] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        num_r[i]  <= {n_in[NW-2:0], 1'b0};
        quot_r[i] <= {q_in[NW-2:0], take};
        den_r[i]  <= d_in;
        side_r[i] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quot  = quot_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the thermistor beta-equation temperature core.
`timescale 1ns / 1ps

module tb;
  import tbc_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    status_t                  status;
  } temp_result_t;

  class celsius_board;
    longint unsigned series_ohms, nominal_ohms, beta_k;
    longint          t0_centi;
    temp_result_t    pending_temps[$];
    int              errors;

    function new();
      series_ohms  = 10000;
      nominal_ohms = 10000;
      beta_k       = 3900;
      t0_centi     = 2500;
      errors       = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      longint v;
      case (idx)
        REG_SERIES, REG_NOMINAL: begin
          v = longint'(data);
          if (v < 1) v = 1;
          if (v > 1000000) v = 1000000;
          if (idx == REG_SERIES) series_ohms = v;
          else nominal_ohms = v;
        end
        REG_BETA: begin
          v = longint'(data[BETA_W-1:0]);
          if (v < 1) v = 1;
          if (v > 10000) v = 10000;
          beta_k = v;
        end
        REG_T0: begin
          v = longint'($signed(data[T0_W-1:0]));
          if (v < -4000) v = -4000;
          if (v > 15000) v = 15000;
          t0_centi = v;
        end
      endcase
    endfunction

    // log2 in Q30: top-bit index, then 30 squaring rounds on the mantissa
    function longint unsigned log2_q30(longint unsigned x);
      int k;
      longint unsigned m, r, b;
      k = 0;
      for (int i = 0; i < 64; i++) if (x[i]) k = i;
      m = (k > 30) ? (x >> (k - 30)) : (x << (30 - k));
      r = longint'(k) << 30;
      b = 64'd1 << 29;
      repeat (30) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          r = r | b;
        end
        b = b >> 1;
      end
      return r;
    endfunction

    function temp_result_t beta_to_centi(logic [ADC_W-1:0] code);
      temp_result_t    res;
      longint unsigned num, den, mag, ln_mag, a_mag, recip_t0, tk, one_q44;
      longint          d, a, y, c;
      one_q44 = 64'd100 << 44;
      if (code == 0) begin
        res.temp = OUT_MIN; res.status = ST_ZERO;
      end else if (code == 16'hFFFF) begin
        res.temp = OUT_MAX; res.status = ST_FULL;
      end else begin
        num = series_ohms * (64'd65535 - longint'(code));
        den = longint'(code) * nominal_ohms;
        d = longint'(log2_q30(num)) - longint'(log2_q30(den));
        mag = (d < 0) ? longint'(-d) : longint'(d);
        ln_mag = ((mag >> 2) * 64'd744261118) >> 28;
        a_mag = (ln_mag << 14) / beta_k;
        a = (d < 0) ? -longint'(a_mag) : longint'(a_mag);
        recip_t0 = one_q44 / longint'(t0_centi + 27315);
        y = a + longint'(recip_t0);
        res.status = ST_OK;
        if (y <= 0) begin
          res.temp = OUT_MAX; res.status = ST_SAT;
        end else begin
          tk = (one_q44 + longint'(y) / 2) / longint'(y);
          if (tk > 60082) begin
            res.temp = OUT_MAX; res.status = ST_SAT;
          end else begin
            c = longint'(tk) - 27315;
            if (c < -27315) begin
              res.temp = OUT_MIN; res.status = ST_SAT;
            end else res.temp = c[TEMP_W-1:0];
          end
        end
      end
      return res;
    endfunction

    function void note_sample(logic [ADC_W-1:0] code);
      pending_temps.push_back(beta_to_centi(code));
    endfunction

    task check_temp(logic signed [TEMP_W-1:0] temp, logic [1:0] status);
      temp_result_t exp_r;
      if (pending_temps.size() == 0) begin
        report($sformatf("unexpected result temp=%0d status=%0d", temp, status));
      end else begin
        exp_r = pending_temps.pop_front();
        if (temp !== exp_r.temp)
          report($sformatf("temperature_centi got %0d want %0d", temp, exp_r.temp));
        if (status !== exp_r.status)
          report($sformatf("status got %0d want %0d", status, exp_r.status));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tbc_in_if  in_if();
  tbc_out_if out_if();

  thermistor_beta_to_celsius_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if.sink),
    .out_ch  (out_if.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  celsius_board board = new();
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      board.check_temp(out_if.temperature_centi, out_if.status);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (rst_n && stall_on && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        n = $urandom_range(1, 7);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_if.ready = rst_n;
      end
    end
  end

  task send_sample(logic [ADC_W-1:0] code);
    int n;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid    = 1'b1;
    in_if.adc_code = code;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_sample(code);
  endtask

  task go_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (board.pending_temps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task load_regs(logic [19:0] rs, logic [19:0] r0, logic [19:0] bk, logic [19:0] t0);
    write_reg(REG_SERIES, rs);
    write_reg(REG_NOMINAL, r0);
    write_reg(REG_BETA, bk);
    write_reg(REG_T0, t0);
  endtask

  task directed_codes();
    logic [ADC_W-1:0] codes[$];
    codes = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h8000,
              16'h7FFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h1000, 16'hF000};
    foreach (codes[i]) send_sample(codes[i]);
  endtask

  function logic [ADC_W-1:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return ADC_W'($urandom_range(0, 40));
      1:       return 16'hFFFF - ADC_W'($urandom_range(0, 40));
      default: return ADC_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task random_codes(int n);
    repeat (n) send_sample(pick_code());
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_SERIES;
    cfg_data       = '0;
    in_if.valid    = 1'b0;
    in_if.adc_code = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values; long output hold-off so the pipeline backs up
    directed_codes();
    hold_req = 1'b1;
    repeat (170) send_sample(ADC_W'($urandom_range(0, 16'hFFFF)));
    go_idle();

    load_regs(20'd1, 20'd1000000, 20'd1, 20'hFF060);          // T0 = -4000
    directed_codes();
    random_codes(40);
    go_idle();

    load_regs(20'd1000000, 20'd1, 20'd10000, 20'd15000);
    directed_codes();
    random_codes(40);
    go_idle();

    // out-of-range values clamp on write
    load_regs(20'd0, 20'hFFFFF, 20'h3FFF, 20'h04000);
    directed_codes();
    random_codes(40);
    go_idle();
    load_regs(20'hFFFFF, 20'd0, 20'd0, 20'h03FFF);
    directed_codes();
    random_codes(40);
    go_idle();

    repeat (3) begin
      load_regs(20'($urandom_range(1, 1000000)), 20'($urandom_range(1, 1000000)),
                20'($urandom_range(1, 10000)),
                20'($signed($urandom_range(0, 19000)) - 4000));
      random_codes(30);
      go_idle();
      random_codes(15);
      go_idle();
    end

    load_regs(20'd10000, 20'd10000, 20'd3900, 20'd2500);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    random_codes(80);
    go_idle();
    repeat (200) @(posedge clk);

    if (board.errors == 0 && board.pending_temps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tbc_pkg.sv
rtl/core/tbc_ifs.sv
rtl/core/tbc_logratio.sv
rtl/core/tbc_div.sv
rtl/core/thermistor_beta_to_celsius_core.sv
verif/tb.sv
